// File: hw/rtl/ias_pkg.sv
// ----------------------------------------------------------------------------
// ias_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ias_pkg;

  localparam int WORD_BITS = 40;
  localparam int PC_BITS   = 13;
  localparam int ADDR_BITS = 12;
  localparam int OP_BITS   = 8;
  localparam int HALF_BITS = 20;
  localparam int STEP_BITS = 21;

  localparam logic [STEP_BITS-1:0] RUN_BUDGET = 21'h100000;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_RUN   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_DIV0    = 2'd2;
  localparam logic [1:0] ST_BUDGET  = 2'd3;

  localparam logic [OP_BITS-1:0] OP_LOAD     = 8'd1;
  localparam logic [OP_BITS-1:0] OP_LOAD_NEG = 8'd2;
  localparam logic [OP_BITS-1:0] OP_LOAD_ABS = 8'd3;
  localparam logic [OP_BITS-1:0] OP_LOAD_NAB = 8'd4;
  localparam logic [OP_BITS-1:0] OP_ADD      = 8'd5;
  localparam logic [OP_BITS-1:0] OP_SUB      = 8'd6;
  localparam logic [OP_BITS-1:0] OP_ADD_ABS  = 8'd7;
  localparam logic [OP_BITS-1:0] OP_SUB_ABS  = 8'd8;
  localparam logic [OP_BITS-1:0] OP_LOAD_MQM = 8'd9;
  localparam logic [OP_BITS-1:0] OP_LOAD_MQ  = 8'd10;
  localparam logic [OP_BITS-1:0] OP_MUL      = 8'd11;
  localparam logic [OP_BITS-1:0] OP_DIV      = 8'd12;
  localparam logic [OP_BITS-1:0] OP_JUMP_L   = 8'd13;
  localparam logic [OP_BITS-1:0] OP_JUMP_R   = 8'd14;
  localparam logic [OP_BITS-1:0] OP_JUMPP_L  = 8'd15;
  localparam logic [OP_BITS-1:0] OP_JUMPP_R  = 8'd16;
  localparam logic [OP_BITS-1:0] OP_STOR_L   = 8'd18;
  localparam logic [OP_BITS-1:0] OP_STOR_R   = 8'd19;
  localparam logic [OP_BITS-1:0] OP_LSH      = 8'd20;
  localparam logic [OP_BITS-1:0] OP_RSH      = 8'd21;
  localparam logic [OP_BITS-1:0] OP_STOR     = 8'd33;

  typedef enum logic [3:0] {
    DP_NOP, DP_LATCH, DP_RUN_INIT, DP_MEM_WR_IN, DP_MEM_RD, DP_LOAD_IR,
    DP_STEP, DP_ALU, DP_MD_START, DP_MD_WB, DP_NEXT_HALF, DP_PC_INC
  } dp_op_t;

  typedef enum logic [1:0] {ASRC_IN, ASRC_PC, ASRC_AR} asrc_t;

  typedef enum logic [1:0] {RES_ZERO, RES_READ, RES_RUN} res_kind_t;

  typedef struct packed {
    dp_op_t     op;
    logic       amod;
    asrc_t      asrc;
    logic       res_load;
    res_kind_t  res_kind;
    logic [1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic               run_ok;
    logic               budget_out;
    logic               left_half;
    logic [OP_BITS-1:0] opcode;
    logic               ac_pos;
    logic               m_zero;
    logic               md_done;
  } dp_sts_t;

endpackage

// File: hw/rtl/ias_muldiv.sv
// ----------------------------------------------------------------------------
// ias_muldiv
// Serial 40-bit signed multiply (shift-add) and divide (restoring).
// ----------------------------------------------------------------------------
module ias_muldiv import ias_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 is_div,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  output logic                 done,
  output logic [WORD_BITS-1:0] hi,
  output logic [WORD_BITS-1:0] lo
);

  logic                 busy;
  logic                 fin;
  logic                 fix;
  logic                 div_mode;
  logic [5:0]           cnt;
  logic [WORD_BITS-1:0] mcand;
  logic [WORD_BITS:0]   hi_r;
  logic [WORD_BITS-1:0] lo_r;
  logic                 neg_q;
  logic                 neg_r;

  logic [WORD_BITS:0]   mcand_x;
  logic [WORD_BITS:0]   mul_sum;
  logic [WORD_BITS:0]   div_t;
  logic                 div_ge;

  assign mcand_x = {mcand[WORD_BITS-1], mcand};

  always_comb begin
    if (!lo_r[0]) begin
      mul_sum = hi_r;
    end else if (cnt == 6'(WORD_BITS - 1)) begin
      mul_sum = hi_r - mcand_x;
    end else begin
      mul_sum = hi_r + mcand_x;
    end
  end

  assign div_t  = {hi_r[WORD_BITS-1:0], lo_r[WORD_BITS-1]};
  assign div_ge = div_t >= {1'b0, mcand};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      fix  <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      fin      <= 1'b0;
      fix      <= 1'b0;
      div_mode <= is_div;
      cnt      <= '0;
      hi_r     <= '0;
      if (is_div) begin
        lo_r  <= a[WORD_BITS-1] ? -a : a;
        mcand <= b[WORD_BITS-1] ? -b : b;
        neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
        neg_r <= a[WORD_BITS-1];
      end else begin
        lo_r  <= b;
        mcand <= a;
      end
    end else if (fix) begin
      // apply signs: quotient truncates toward zero, remainder follows dividend
      fix  <= 1'b0;
      fin  <= 1'b1;
      lo_r <= neg_q ? -lo_r : lo_r;
      hi_r <= neg_r ? -hi_r : hi_r;
    end else if (busy) begin
      if (div_mode) begin
        hi_r <= div_ge ? div_t - {1'b0, mcand} : div_t;
        lo_r <= {lo_r[WORD_BITS-2:0], div_ge};
      end else begin
        hi_r <= {mul_sum[WORD_BITS], mul_sum[WORD_BITS:1]};
        lo_r <= {mul_sum[0], lo_r[WORD_BITS-1:1]};
      end
      cnt <= cnt + 6'd1;
      if (cnt == 6'(WORD_BITS - 1)) begin
        busy <= 1'b0;
        if (div_mode) begin
          fix <= 1'b1;
        end else begin
          fin <= 1'b1;
        end
      end
    end
  end

  assign done = fin;
  assign hi   = hi_r[WORD_BITS-1:0];
  assign lo   = lo_r;

endmodule

// File: hw/rtl/ias_datapath.sv
// ----------------------------------------------------------------------------
// ias_datapath
// Word memory, address reduction, processor registers and result register.
// ----------------------------------------------------------------------------
module ias_datapath import ias_pkg::*; #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dp_cmd_t                     cmd,
  output dp_sts_t                     sts,
  input  logic [ADDR_BITS-1:0]        addr,
  input  logic [WORD_BITS-1:0]        wdata,
  input  logic [ADDR_BITS-1:0]        start_pc,
  input  logic [PC_BITS-1:0]          end_pc,
  output logic [WORD_BITS-1:0]        rdata,
  output logic [1:0]                  status,
  output logic signed [WORD_BITS-1:0] acc,
  output logic signed [WORD_BITS-1:0] mq,
  output logic [PC_BITS-1:0]          final_pc
);

  localparam int AW          = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int RECIP_SHIFT = 24;
  localparam logic [20:0] RECIP = 21'((1 << RECIP_SHIFT) / MEM_WORDS);

  logic [WORD_BITS-1:0] mem [MEM_WORDS];

  logic [ADDR_BITS-1:0] addr_q;
  logic [WORD_BITS-1:0] wdata_q;
  logic [ADDR_BITS-1:0] start_q;
  logic [PC_BITS-1:0]   end_q;

  logic [WORD_BITS-1:0] ac;
  logic [WORD_BITS-1:0] mqr;
  logic [PC_BITS-1:0]   pc;
  logic [HALF_BITS-1:0] ibuf;
  logic [OP_BITS-1:0]   opr;
  logic [ADDR_BITS-1:0] ar;
  logic                 left_half;
  logic [STEP_BITS-1:0] steps;

  logic [WORD_BITS-1:0] mdata;
  logic [WORD_BITS-1:0] m_abs;

  // address reduction modulo MEM_WORDS: reciprocal estimate, then one correction
  logic [PC_BITS-1:0] am_sel;
  logic [33:0]        am_prod;
  logic [PC_BITS-1:0] am_raw;
  logic [9:0]         am_q;
  logic [22:0]        am_qn;
  logic [13:0]        am_rem;
  logic [13:0]        am_fix;
  logic [AW-1:0]      maddr;

  always_comb begin
    case (cmd.asrc)
      ASRC_IN: am_sel = {1'b0, addr_q};
      ASRC_PC: am_sel = pc;
      ASRC_AR: am_sel = {1'b0, ar};
      default: am_sel = pc;
    endcase
  end

  assign am_prod = 34'(am_sel) * 34'(RECIP);
  assign am_qn   = 23'(am_q) * 23'(MEM_WORDS);
  assign am_rem  = 14'(am_raw) - am_qn[13:0];
  assign am_fix  = (am_rem >= 14'(MEM_WORDS)) ? am_rem - 14'(MEM_WORDS) : am_rem;

  always_ff @(posedge clk) begin
    if (cmd.amod) begin
      am_raw <= am_sel;
      am_q   <= am_prod[33:24];
    end
    maddr <= am_fix[AW-1:0];
  end

  // multiply / divide unit
  logic                 md_start;
  logic                 md_div;
  logic                 md_done;
  logic [WORD_BITS-1:0] md_hi;
  logic [WORD_BITS-1:0] md_lo;

  assign md_start = cmd.op == DP_MD_START;
  assign md_div   = opr == OP_DIV;

  ias_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .is_div (md_div),
    .a      (md_div ? ac : mqr),
    .b      (mdata),
    .done   (md_done),
    .hi     (md_hi),
    .lo     (md_lo)
  );

  // memory port
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wd;
  logic                 is_store;

  assign is_store = (opr == OP_STOR_L) || (opr == OP_STOR_R) || (opr == OP_STOR);

  always_comb begin
    mem_we = 1'b0;
    mem_wd = wdata_q;
    if (cmd.op == DP_MEM_WR_IN) begin
      mem_we = 1'b1;
    end else if (cmd.op == DP_ALU && is_store) begin
      mem_we = 1'b1;
      case (opr)
        OP_STOR_L: mem_wd = {mdata[39:32], ac[11:0], mdata[19:0]};
        OP_STOR_R: mem_wd = {mdata[39:12], ac[11:0]};
        default:   mem_wd = ac;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[maddr] <= mem_wd;
    end
    if (cmd.op == DP_MEM_RD) begin
      mdata <= mem[maddr];
    end
    m_abs <= mdata[WORD_BITS-1] ? -mdata : mdata;
  end

  // processor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ac        <= '0;
      mqr       <= '0;
      pc        <= '0;
      ibuf      <= '0;
      opr       <= '0;
      ar        <= '0;
      left_half <= 1'b1;
      steps     <= '0;
    end else begin
      case (cmd.op)
        DP_RUN_INIT: begin
          ac    <= '0;
          mqr   <= '0;
          pc    <= {1'b0, start_q};
          steps <= '0;
        end
        DP_LOAD_IR: begin
          ibuf      <= mdata[19:0];
          opr       <= mdata[39:32];
          ar        <= mdata[31:20];
          left_half <= 1'b1;
        end
        DP_STEP: steps <= steps + 1'b1;
        DP_ALU: begin
          case (opr)
            OP_LOAD:     ac  <= mdata;
            OP_LOAD_NEG: ac  <= -mdata;
            OP_LOAD_ABS: ac  <= m_abs;
            OP_LOAD_NAB: ac  <= -m_abs;
            OP_ADD:      ac  <= ac + mdata;
            OP_SUB:      ac  <= ac - mdata;
            OP_ADD_ABS:  ac  <= ac + m_abs;
            OP_SUB_ABS:  ac  <= ac - m_abs;
            OP_LOAD_MQM: mqr <= mdata;
            OP_LOAD_MQ:  ac  <= mqr;
            OP_LSH:      ac  <= {ac[WORD_BITS-2:0], 1'b0};
            OP_RSH:      ac  <= {ac[WORD_BITS-1], ac[WORD_BITS-1:1]};
            OP_JUMP_L, OP_JUMPP_L: begin
              pc        <= {1'b0, ar};
              opr       <= mdata[39:32];
              ar        <= mdata[31:20];
              ibuf      <= mdata[19:0];
              left_half <= 1'b1;
            end
            OP_JUMP_R, OP_JUMPP_R: begin
              pc        <= {1'b0, ar};
              opr       <= mdata[19:12];
              ar        <= mdata[11:0];
              left_half <= 1'b0;
            end
            default: ;
          endcase
        end
        DP_MD_WB: begin
          ac  <= md_hi;
          mqr <= md_lo;
        end
        DP_NEXT_HALF: begin
          opr       <= ibuf[19:12];
          ar        <= ibuf[11:0];
          left_half <= 1'b0;
        end
        DP_PC_INC: pc <= pc + 1'b1;
        default: ;
      endcase
    end
  end

  // input capture and result register
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LATCH) begin
      addr_q  <= addr;
      wdata_q <= wdata;
      start_q <= start_pc;
      end_q   <= end_pc;
    end
    if (cmd.res_load) begin
      rdata    <= '0;
      status   <= ST_OK;
      acc      <= '0;
      mq       <= '0;
      final_pc <= '0;
      case (cmd.res_kind)
        RES_READ: rdata <= mdata;
        RES_RUN: begin
          status   <= cmd.res_status;
          acc      <= ac;
          mq       <= mqr;
          final_pc <= pc;
        end
        default: ;
      endcase
    end
  end

  assign sts.run_ok     = (pc < end_q) && (14'(pc) < 14'(MEM_WORDS));
  assign sts.budget_out = steps == RUN_BUDGET;
  assign sts.left_half  = left_half;
  assign sts.opcode     = opr;
  assign sts.ac_pos     = (ac != '0) && !ac[WORD_BITS-1];
  assign sts.m_zero     = mdata == '0;
  assign sts.md_done    = md_done;

endmodule

// File: hw/rtl/ias_ctrl.sv
// ----------------------------------------------------------------------------
// ias_ctrl
// Sequencer for memory access, fetch, execute and result delivery.
// ----------------------------------------------------------------------------
module ias_ctrl import ias_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_W_A, S_W_B, S_W_DO, S_R_A, S_R_B, S_R_RD, S_RUN_INIT,
    S_CHECK, S_F_B, S_F_RD, S_F_IR, S_EXEC, S_O_B, S_O_RD, S_O_ABS,
    S_OPER, S_MD_WAIT, S_MD_WB, S_NEXT, S_DONE
  } state_t;

  state_t     state;
  state_t     state_next;
  res_kind_t  res_kind;
  logic [1:0] res_status;
  logic       set_res;
  res_kind_t  set_kind;
  logic [1:0] set_status;
  logic       take;

  assign in_stall = state != S_IDLE;
  assign take     = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    cmd.op         = DP_NOP;
    cmd.asrc       = ASRC_IN;
    cmd.res_kind   = res_kind;
    cmd.res_status = res_status;
    state_next     = state;
    set_res        = 1'b0;
    set_kind       = RES_ZERO;
    set_status     = ST_OK;
    case (state)
      S_IDLE: begin
        if (take) begin
          cmd.op = DP_LATCH;
          case (in_func)
            FUNC_WRITE: state_next = S_W_A;
            FUNC_READ:  state_next = S_R_A;
            FUNC_RUN:   state_next = S_RUN_INIT;
            default: begin
              state_next = S_DONE;
              set_res    = 1'b1;
            end
          endcase
        end
      end
      S_W_A: begin
        cmd.amod   = 1'b1;
        state_next = S_W_B;
      end
      S_W_B: state_next = S_W_DO;
      S_W_DO: begin
        cmd.op     = DP_MEM_WR_IN;
        state_next = S_DONE;
        set_res    = 1'b1;
      end
      S_R_A: begin
        cmd.amod   = 1'b1;
        state_next = S_R_B;
      end
      S_R_B: state_next = S_R_RD;
      S_R_RD: begin
        cmd.op     = DP_MEM_RD;
        state_next = S_DONE;
        set_res    = 1'b1;
        set_kind   = RES_READ;
      end
      S_RUN_INIT: begin
        cmd.op     = DP_RUN_INIT;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.run_ok) begin
          cmd.amod   = 1'b1;
          cmd.asrc   = ASRC_PC;
          state_next = S_F_B;
        end else begin
          state_next = S_DONE;
          set_res    = 1'b1;
          set_kind   = RES_RUN;
        end
      end
      S_F_B: state_next = S_F_RD;
      S_F_RD: begin
        cmd.op     = DP_MEM_RD;
        state_next = S_F_IR;
      end
      S_F_IR: begin
        cmd.op     = DP_LOAD_IR;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.budget_out) begin
          state_next = S_DONE;
          set_res    = 1'b1;
          set_kind   = RES_RUN;
          set_status = ST_BUDGET;
        end else begin
          cmd.op     = DP_STEP;
          cmd.amod   = 1'b1;
          cmd.asrc   = ASRC_AR;
          state_next = S_O_B;
        end
      end
      S_O_B: state_next = S_O_RD;
      S_O_RD: begin
        cmd.op     = DP_MEM_RD;
        state_next = S_O_ABS;
      end
      S_O_ABS: state_next = S_OPER;
      S_OPER: begin
        case (sts.opcode)
          OP_LOAD, OP_LOAD_NEG, OP_LOAD_ABS, OP_LOAD_NAB, OP_ADD, OP_SUB,
          OP_ADD_ABS, OP_SUB_ABS, OP_LOAD_MQM, OP_LOAD_MQ, OP_LSH, OP_RSH,
          OP_STOR_L, OP_STOR_R, OP_STOR: begin
            cmd.op     = DP_ALU;
            state_next = S_NEXT;
          end
          OP_MUL: begin
            cmd.op     = DP_MD_START;
            state_next = S_MD_WAIT;
          end
          OP_DIV: begin
            if (sts.m_zero) begin
              state_next = S_DONE;
              set_res    = 1'b1;
              set_kind   = RES_RUN;
              set_status = ST_DIV0;
            end else begin
              cmd.op     = DP_MD_START;
              state_next = S_MD_WAIT;
            end
          end
          OP_JUMP_L, OP_JUMP_R: begin
            cmd.op     = DP_ALU;
            state_next = S_EXEC;
          end
          OP_JUMPP_L, OP_JUMPP_R: begin
            if (sts.ac_pos) begin
              cmd.op     = DP_ALU;
              state_next = S_EXEC;
            end else begin
              state_next = S_NEXT;
            end
          end
          default: begin
            state_next = S_DONE;
            set_res    = 1'b1;
            set_kind   = RES_RUN;
            set_status = ST_INVALID;
          end
        endcase
      end
      S_MD_WAIT: begin
        if (sts.md_done) begin
          state_next = S_MD_WB;
        end
      end
      S_MD_WB: begin
        cmd.op     = DP_MD_WB;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (sts.left_half) begin
          cmd.op     = DP_NEXT_HALF;
          state_next = S_EXEC;
        end else begin
          cmd.op     = DP_PC_INC;
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        // load the result register once the previous item has left
        if (!out_valid || !out_stall) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      res_kind   <= RES_ZERO;
      res_status <= ST_OK;
    end else begin
      state <= state_next;
      if (set_res) begin
        res_kind   <= set_kind;
        res_status <= set_status;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !(out_valid && out_stall))
    else $error("result register loaded while a result is stalled");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    take |=> state != S_IDLE)
    else $error("accepted item left the controller idle");

  a_md_writeback: assert property (@(posedge clk) disable iff (rst)
    (state == S_MD_WAIT && sts.md_done) |=> cmd.op == DP_MD_WB)
    else $error("finished multiply/divide not written back");

endmodule

// File: hw/rtl/ias_processor_execute_unit.sv
// ----------------------------------------------------------------------------
// ias_processor_execute_unit
// IAS-style 40-bit processor: word write, word read and program run items.
// ----------------------------------------------------------------------------
// A write or read goes through the registered address reduction to the memory;
// other func codes go straight to the result. A run fetches each word and each
// operand the same way; MUL and DIV wait on the serial multiply/divide unit, so
// a run takes as long as its program. One item is in work at a time.
// Reset clears the controller and processor registers; memory words stay
// undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
module ias_processor_execute_unit import ias_pkg::*; #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic [ADDR_BITS-1:0]        addr,
  input  logic [WORD_BITS-1:0]        wdata,
  input  logic [ADDR_BITS-1:0]        start_pc,
  input  logic [PC_BITS-1:0]          end_pc,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [WORD_BITS-1:0]        rdata,
  output logic [1:0]                  status,
  output logic signed [WORD_BITS-1:0] acc,
  output logic signed [WORD_BITS-1:0] mq,
  output logic [PC_BITS-1:0]          final_pc
);

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: accepts an item only when idle, holds the result until taken
  ias_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_func   (func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: memory, address reduction, AC/MQ/PC and result register
  ias_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .addr     (addr),
    .wdata    (wdata),
    .start_pc (start_pc),
    .end_pc   (end_pc),
    .rdata    (rdata),
    .status   (status),
    .acc      (acc),
    .mq       (mq),
    .final_pc (final_pc)
  );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ias_processor_execute_unit: a directed table of
// word writes, reads and short programs, then random program episodes, each
// result compared field by field against a behavioral model or a table value.
// ----------------------------------------------------------------------------
module tb;
  import ias_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;     // unused func code, answers zeros
  localparam int STEP_CAP   = 200;             // most instructions a run may execute in the bench
  localparam int ITEM_GOAL  = 1300;
  localparam int QUIET_AT   = 1150;            // no idling from here on
  localparam int PRESS_AT   = 300;             // start the long receiver hold here
  localparam int CYCLE_CAP  = 60000000;
  localparam logic [39:0] W_MIN  = 40'h80_0000_0000;
  localparam logic [39:0] W_MAX  = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] W_ONES = 40'hFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]  func;
    logic [11:0] addr;
    logic [39:0] wdata;
    logic [11:0] spc;
    logic [12:0] epc;
  } item_t;

  typedef struct {
    logic [39:0] rdata;
    logic [1:0]  status;
    logic [39:0] acc;
    logic [39:0] mq;
    logic [12:0] fpc;
  } outcome_t;

  typedef struct {
    item_t    it;
    bit       typed;
    outcome_t want;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = '0;
  logic [11:0] addr = '0;
  logic [39:0] wdata = '0;
  logic [11:0] start_pc = '0;
  logic [12:0] end_pc = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [39:0] rdata;
  logic [1:0]  status;
  logic signed [39:0] acc;
  logic signed [39:0] mq;
  logic [12:0] final_pc;

  ias_processor_execute_unit dut (.*);

  // Shadow of the word store plus a map of which words hold defined data.
  logic [39:0] shadow_mem [4096];
  bit          defined_word [4096];
  outcome_t    pending_results [$];

  int errors = 0;
  int sent = 0, runs = 0, halts = 0, reads = 0, writes = 0;
  longint cycles = 0;
  bit quiet = 0, press = 0;

  logic [7:0] legal_ops [21] = '{OP_LOAD, OP_LOAD_NEG, OP_LOAD_ABS, OP_LOAD_NAB,
    OP_ADD, OP_SUB, OP_ADD_ABS, OP_SUB_ABS, OP_LOAD_MQM, OP_LOAD_MQ, OP_MUL, OP_DIV,
    OP_JUMP_L, OP_JUMP_R, OP_JUMPP_L, OP_JUMPP_R, OP_STOR_L, OP_STOR_R, OP_LSH,
    OP_RSH, OP_STOR};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // Execute a program on the shadow store. Clear ok when the program touches
  // an undefined word or runs longer than the bench allows.
  function automatic void execute_program(input logic [11:0] s, input logic [12:0] e,
                                          output outcome_t r, output bit ok);
    logic [39:0] ac, mqr, w, m;
    logic [19:0] hold;
    logic [7:0]  op;
    logic [11:0] ar;
    logic [12:0] pc;
    logic signed [79:0] prod;
    longint a, b;
    int steps;
    bit left, busy, halted, jump, jl, pos;
    ok = 1; r = '{default: '0};
    ac = '0; mqr = '0; pc = {1'b0, s}; steps = 0; halted = 0;
    while (!halted && pc < e && pc < 13'd4096) begin
      if (!defined_word[pc[11:0]]) ok = 0;
      w = shadow_mem[pc[11:0]];
      hold = w[19:0]; op = w[39:32]; ar = w[31:20]; left = 1; busy = 1;
      while (busy) begin
        if (steps >= STEP_CAP) begin
          ok = 0; halted = 1; break;
        end
        steps++;
        if (!defined_word[ar]) ok = 0;
        m = shadow_mem[ar];
        pos = (ac != 0) && !ac[39];
        jump = 0; jl = 0;
        case (op)
          OP_LOAD:     ac = m;
          OP_LOAD_NEG: ac = -m;
          OP_LOAD_ABS: ac = m[39] ? -m : m;
          OP_LOAD_NAB: ac = m[39] ? m : -m;
          OP_ADD:      ac = ac + m;
          OP_SUB:      ac = ac - m;
          OP_ADD_ABS:  ac = ac + (m[39] ? -m : m);
          OP_SUB_ABS:  ac = ac - (m[39] ? -m : m);
          OP_LOAD_MQM: mqr = m;
          OP_LOAD_MQ:  ac = mqr;
          OP_MUL: begin
            prod = $signed({{40{mqr[39]}}, mqr}) * $signed({{40{m[39]}}, m});
            ac = prod[79:40];
            mqr = prod[39:0];
          end
          OP_DIV: begin
            if (m == 0) begin
              r.status = ST_DIV0; halted = 1;
            end else begin
              a = $signed(ac);
              b = $signed(m);
              mqr = a / b;        // truncates toward zero, wraps on min / -1
              ac = a % b;
            end
          end
          OP_JUMP_L:  begin jump = 1; jl = 1; end
          OP_JUMP_R:  jump = 1;
          OP_JUMPP_L: if (pos) begin jump = 1; jl = 1; end
          OP_JUMPP_R: if (pos) jump = 1;
          OP_STOR_L:  shadow_mem[ar] = {m[39:32], ac[11:0], m[19:0]};
          OP_STOR_R:  shadow_mem[ar] = {m[39:12], ac[11:0]};
          OP_LSH:     ac = ac << 1;
          OP_RSH:     ac = {ac[39], ac[39:1]};
          OP_STOR:    shadow_mem[ar] = ac;
          default: begin
            r.status = ST_INVALID; halted = 1;
          end
        endcase
        if (halted) break;
        if (jump) begin
          // continue at once in the target word, without the limit check
          w = shadow_mem[ar];
          pc = {1'b0, ar};
          if (jl) begin
            op = w[39:32]; hold = w[19:0]; ar = w[31:20];
          end else begin
            op = w[19:12]; ar = w[11:0];
          end
          left = jl;
        end else if (left) begin
          op = hold[19:12]; ar = hold[11:0]; left = 0;
        end else begin
          pc = pc + 13'd1; busy = 0;
        end
      end
    end
    r.acc = ac; r.mq = mqr; r.fpc = pc;
  endfunction

  // Apply one item to the shadow state; ok is cleared when the item must not
  // be sent (shadow state then stays as it was).
  function automatic void predict_item(input item_t it, output outcome_t r, output bit ok);
    logic [39:0] saved [4096];
    ok = 1; r = '{default: '0};
    case (it.func)
      FUNC_WRITE: begin
        shadow_mem[it.addr] = it.wdata;
        defined_word[it.addr] = 1;
      end
      FUNC_READ: begin
        ok = defined_word[it.addr];
        r.rdata = shadow_mem[it.addr];
      end
      FUNC_RUN: begin
        saved = shadow_mem;
        execute_program(it.spc, it.epc, r, ok);
        if (!ok) shadow_mem = saved;
      end
      default: ;
    endcase
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch on %s at cycle %0d: got %h want %h", what, cycles, got, want);
  endtask

  // Offer one item and hold it until accepted; a rejected run or read falls back
  // to a read of a known word.
  task automatic send(input item_t it, input bit typed = 0, input outcome_t want = '{default: '0});
    outcome_t r;
    bit ok;
    predict_item(it, r, ok);
    if (!ok) begin
      it = '{func: FUNC_READ, addr: 12'd104, wdata: '0, spc: '0, epc: '0};
      typed = 0;
      predict_item(it, r, ok);
    end
    if (typed) r = want;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    func <= it.func; addr <= it.addr; wdata <= it.wdata;
    start_pc <= it.spc; end_pc <= it.epc;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(r);
    sent++;
    case (it.func)
      FUNC_RUN:   begin runs++; if (r.status != ST_OK) halts++; end
      FUNC_READ:  reads++;
      FUNC_WRITE: writes++;
      default: ;
    endcase
    if (sent == PRESS_AT) press <= 1'b1;
    if (sent == QUIET_AT) quiet <= 1'b1;
  endtask

  // Receiver: check each accepted result, then stall in random bursts, plus
  // one long hold so the block backs up into its input.
  initial begin : receiver
    int hold_cnt;
    bit press_done;
    outcome_t w;
    hold_cnt = 0; press_done = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("unexpected result at cycle %0d", cycles);
        end else begin
          w = pending_results.pop_front();
          if (rdata !== w.rdata)    report("rdata", rdata, w.rdata);
          if (status !== w.status)  report("status", status, w.status);
          if (acc !== w.acc)        report("acc", acc, w.acc);
          if (mq !== w.mq)          report("mq", mq, w.mq);
          if (final_pc !== w.fpc)   report("final_pc", final_pc, w.fpc);
        end
      end
      if (press && !press_done) begin
        press_done = 1;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic row_t row(input logic [1:0] f, input logic [11:0] a, input logic [39:0] d,
                               input logic [11:0] s, input logic [12:0] e, input bit typed = 0,
                               input logic [39:0] xr = '0, input logic [1:0] xs = '0,
                               input logic [39:0] xa = '0, input logic [39:0] xm = '0,
                               input logic [12:0] xp = '0);
    row.it = '{func: f, addr: a, wdata: d, spc: s, epc: e};
    row.typed = typed;
    row.want = '{rdata: xr, status: xs, acc: xa, mq: xm, fpc: xp};
  endfunction

  function automatic logic [39:0] rand_word();
    case ($urandom_range(0, 5))
      0: return W_MIN;
      1: return W_MAX;
      2: return '0;
      3: return W_ONES;
      4: return 40'($urandom_range(0, 300));
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [19:0] rand_instr(input int base, input int n, input int data);
    logic [7:0] op;
    logic [11:0] a;
    op = ($urandom_range(0, 11) == 0) ? 8'($urandom) : legal_ops[$urandom_range(0, 20)];
    if (op inside {OP_JUMP_L, OP_JUMP_R, OP_JUMPP_L, OP_JUMPP_R} || $urandom_range(0, 4) == 0)
      a = 12'(base + $urandom_range(0, n - 1));
    else
      a = 12'(data + $urandom_range(0, 7));
    return {op, a};
  endfunction

  initial begin : stimulus
    row_t tab [$];
    int data, base, n, s, e;
    // data words: min, max, zero, minus one, scratch
    tab.push_back(row(FUNC_WRITE, 100, W_MIN, 0, 0));
    tab.push_back(row(FUNC_WRITE, 101, W_MAX, 0, 0));
    tab.push_back(row(FUNC_WRITE, 102, '0, 0, 0));
    tab.push_back(row(FUNC_WRITE, 103, W_ONES, 0, 0));
    tab.push_back(row(FUNC_WRITE, 104, 40'h12_3456_789A, 0, 0));
    tab.push_back(row(FUNC_READ, 101, '0, 0, 0, 1, W_MAX));
    tab.push_back(row(FUNC_READ, 100, '0, 0, 0, 1, W_MIN));
    tab.push_back(row(FUNC_NONE, 12'hFFF, W_ONES, 12'hFFF, 13'h1FFF, 1));
    // empty run: start equals end
    tab.push_back(row(FUNC_RUN, 0, '0, 5, 5, 1, '0, ST_OK, '0, '0, 5));
    // invalid opcode in the left half halts at once
    tab.push_back(row(FUNC_WRITE, 10, {8'hFF, 12'd101, OP_LOAD, 12'd101}, 0, 0));
    tab.push_back(row(FUNC_RUN, 0, '0, 10, 11, 1, '0, ST_INVALID, '0, '0, 10));
    // divide by zero keeps the accumulator from before
    tab.push_back(row(FUNC_WRITE, 11, {OP_LOAD, 12'd101, OP_DIV, 12'd102}, 0, 0));
    tab.push_back(row(FUNC_RUN, 0, '0, 11, 12, 1, '0, ST_DIV0, W_MAX, '0, 11));
    // program touching every opcode but JUMP_L, wrap cases and jumps
    tab.push_back(row(FUNC_WRITE, 20, {OP_LOAD_NEG, 12'd100, OP_LOAD_ABS, 12'd100}, 0, 0));
    tab.push_back(row(FUNC_WRITE, 21, {OP_LOAD_NAB, 12'd103, OP_ADD, 12'd101}, 0, 0));
    tab.push_back(row(FUNC_WRITE, 22, {OP_SUB, 12'd103, OP_ADD_ABS, 12'd100}, 0, 0));
    tab.push_back(row(FUNC_WRITE, 23, {OP_SUB_ABS, 12'd103, OP_LOAD_MQM, 12'd100}, 0, 0));
    tab.push_back(row(FUNC_WRITE, 24, {OP_MUL, 12'd103, OP_LOAD_MQ, 12'd102}, 0, 0));
    tab.push_back(row(FUNC_WRITE, 25, {OP_RSH, 12'd102, OP_LSH, 12'd102}, 0, 0));
    tab.push_back(row(FUNC_WRITE, 26, {OP_STOR, 12'd104, OP_STOR_L, 12'd104}, 0, 0));
    tab.push_back(row(FUNC_WRITE, 27, {OP_STOR_R, 12'd104, OP_JUMP_R, 12'd28}, 0, 0));
    tab.push_back(row(FUNC_WRITE, 28, {OP_LOAD, 12'd102, OP_JUMPP_R, 12'd29}, 0, 0));
    tab.push_back(row(FUNC_WRITE, 29, {OP_LOAD, 12'd101, OP_JUMPP_L, 12'd30}, 0, 0));
    tab.push_back(row(FUNC_WRITE, 30, {OP_LOAD, 12'd100, OP_DIV, 12'd103}, 0, 0));
    tab.push_back(row(FUNC_RUN, 0, '0, 20, 31));
    // run that stops at the top of memory
    tab.push_back(row(FUNC_WRITE, 4095, {OP_LOAD, 12'd101, OP_LSH, 12'd102}, 0, 0));
    tab.push_back(row(FUNC_RUN, 0, '0, 4095, 4096));
    tab.push_back(row(FUNC_READ, 104, '0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (tab[i]) send(tab[i].it, tab[i].typed, tab[i].want);

    // Random episodes: lay down data, write a short program over it, run it.
    while (sent < ITEM_GOAL) begin
      data = $urandom_range(0, 4088);
      for (int i = 0; i < 8; i++)
        send('{func: FUNC_WRITE, addr: 12'(data + i), wdata: rand_word(), spc: '0, epc: '0});
      n = $urandom_range(1, 8);
      base = ($urandom_range(0, 9) == 0) ? 4096 - n : $urandom_range(0, 4095 - n);
      for (int i = 0; i < n; i++)
        send('{func: FUNC_WRITE, addr: 12'(base + i),
               wdata: {rand_instr(base, n, data), rand_instr(base, n, data)},
               spc: '0, epc: '0});
      repeat ($urandom_range(1, 3)) begin
        s = base + $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
          0: e = $urandom_range(0, s);
          1: e = 4096;
          default: e = base + n;
        endcase
        send('{func: FUNC_RUN, addr: 12'($urandom), wdata: {8'($urandom), 32'($urandom)},
               spc: 12'(s), epc: 13'(e)});
      end
      send('{func: FUNC_READ, addr: 12'(data + $urandom_range(0, 7)), wdata: '0,
             spc: '0, epc: '0});
      send('{func: FUNC_WRITE, addr: 12'($urandom), wdata: {8'($urandom), 32'($urandom)},
             spc: 12'($urandom), epc: 13'($urandom)});
      if ($urandom_range(0, 3) == 0)
        send('{func: FUNC_NONE, addr: 12'($urandom), wdata: {8'($urandom), 32'($urandom)},
               spc: 12'($urandom), epc: 13'($urandom)});
    end

    // drain: wait for every result, then a little latency margin
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d items: %0d writes, %0d reads, %0d program runs", sent, writes,
             reads, runs);
    $display("%0d runs halted on an invalid opcode or a zero divisor", halts);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
